// ===== design/owm_pkg.sv =====
// Package for the omni wheel drive mixer: field widths, command and register
// codes, fixed-point constants and the Taylor-series tables.
// No dependencies.
package owm_pkg;

    localparam int SINE_FRAC_BITS_DEF = 15;

    localparam int GAIN_W = 12;
    localparam int ANG_W  = 16;
    localparam int ERR_W  = 17;
    localparam int SPD_W  = 8;
    localparam int PWM_W  = 8;
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;
    localparam int WHEELS = 4;

    localparam int DEG90       = 9000;
    localparam int DEG180      = 18000;
    localparam int DEG360      = 36000;
    localparam int RAD_Q30     = 187403;
    localparam int Q30_ONE     = 1 << 30;
    localparam int TURN_DIV    = 4608000;
    localparam int TERM_LAST   = 4;

    typedef enum logic [1:0] {
        CMD_PLAIN = 2'd0,
        CMD_CORR  = 2'd1,
        CMD_TURN  = 2'd2,
        CMD_STOP  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        REG_GAIN  = 3'd0,
        REG_OFF1  = 3'd1,
        REG_OFF2  = 3'd2,
        REG_OFF3  = 3'd3,
        REG_OFF4  = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0]                 turn_gain;
        logic [WHEELS-1:0][ANG_W-1:0]      wheel_offset;
    } cfg_t;

    // Horner step divisors of the sine series, highest term first
    function automatic logic [6:0] term_div(input logic [2:0] k);
        logic [6:0] d;
        case (k)
            3'd0:    d = 7'd110;
            3'd1:    d = 7'd72;
            3'd2:    d = 7'd42;
            3'd3:    d = 7'd20;
            3'd4:    d = 7'd6;
            default: d = 7'd1;
        endcase
        return d;
    endfunction

    // floor(2^32 / divisor); quotient estimate is low by at most one
    function automatic logic [31:0] term_recip(input logic [2:0] k);
        logic [31:0] r;
        case (k)
            3'd0:    r = 32'd39045157;
            3'd1:    r = 32'd59652323;
            3'd2:    r = 32'd102261126;
            3'd3:    r = 32'd214748364;
            3'd4:    r = 32'd715827882;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== design/owm_ifs.sv =====
// Valid/ready channel interfaces for the mixer's command and result ports.
// Depends on owm_pkg.
interface owm_cmd_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        cmd;
    logic [owm_pkg::ANG_W-1:0]         heading_angle;
    logic signed [owm_pkg::ERR_W-1:0]  turn_error;
    logic [owm_pkg::SPD_W-1:0]         speed;
    logic                              motor_enable;

    modport source (output valid, cmd, heading_angle, turn_error, speed, motor_enable,
                    input ready);
    modport sink   (input valid, cmd, heading_angle, turn_error, speed, motor_enable,
                    output ready);
endinterface

interface owm_res_if;
    logic                        valid;
    logic                        ready;
    logic                        dir_one;
    logic [owm_pkg::PWM_W-1:0]   pwm_one;
    logic                        dir_two;
    logic [owm_pkg::PWM_W-1:0]   pwm_two;
    logic                        dir_three;
    logic [owm_pkg::PWM_W-1:0]   pwm_three;
    logic                        dir_four;
    logic [owm_pkg::PWM_W-1:0]   pwm_four;

    modport source (output valid, dir_one, pwm_one, dir_two, pwm_two, dir_three, pwm_three,
                    dir_four, pwm_four, input ready);
    modport sink   (input valid, dir_one, pwm_one, dir_two, pwm_two, dir_three, pwm_three,
                    dir_four, pwm_four, output ready);
endinterface

// ===== design/owm_mul.sv =====
// Shared 32x32 unsigned multiplier with a registered product.
// No package dependencies.
module owm_mul (
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] p
);

    logic [63:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= 64'(a) * 64'(b);
    end

    assign p = p_reg;

endmodule

// ===== design/owm_scale.sv =====
// Serial scaler: quo = floor(mult * num / den), shift-add then shift-subtract.
// Needs num <= den (quotient fits 8 bits); num and den held while busy.
module owm_scale #(
    parameter int NW = 45
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [NW-1:0] den,
    input  logic [7:0]    mult,
    output logic          done,
    output logic [7:0]    quo
);

    localparam int AW = NW + 8;

    logic [AW-1:0] acc_reg, acc_next;
    logic [AW-1:0] dsh_reg, dsh_next;
    logic [7:0]    m_reg, m_next;
    logic [7:0]    q_reg, q_next;
    logic [3:0]    cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    always_comb
    begin
        acc_next  = acc_reg;
        dsh_next  = dsh_reg;
        m_next    = m_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            dsh_next  = AW'(den) << 7;
            m_next    = mult;
            q_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!cnt_reg[3])
            begin
                acc_next = (acc_reg << 1) + (m_reg[7] ? AW'(num) : '0);
                m_next   = m_reg << 1;
            end
            else
            begin
                if (acc_reg >= dsh_reg)
                begin
                    acc_next = acc_reg - dsh_reg;
                    q_next   = {q_reg[6:0], 1'b1};
                end
                else
                begin
                    q_next = {q_reg[6:0], 1'b0};
                end
                dsh_next = dsh_reg >> 1;
            end
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'd15)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        dsh_reg <= dsh_next;
        m_reg   <= m_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

// ===== design/owm_cfg.sv =====
// APB register file: turn gain and the four wheel mounting offsets.
// Depends on owm_pkg.
module owm_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [owm_pkg::APB_AW-1:0]    paddr,
    input  logic [owm_pkg::APB_DW-1:0]    pwdata,
    output logic [owm_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    output owm_pkg::cfg_t                 cfg
);

    owm_pkg::cfg_t cfg_reg, cfg_next;
    logic          wr_en;

    assign wr_en = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr[4:2])
                owm_pkg::REG_GAIN: cfg_next.turn_gain = pwdata[owm_pkg::GAIN_W-1:0];
                owm_pkg::REG_OFF1: cfg_next.wheel_offset[0] = pwdata[owm_pkg::ANG_W-1:0];
                owm_pkg::REG_OFF2: cfg_next.wheel_offset[1] = pwdata[owm_pkg::ANG_W-1:0];
                owm_pkg::REG_OFF3: cfg_next.wheel_offset[2] = pwdata[owm_pkg::ANG_W-1:0];
                owm_pkg::REG_OFF4: cfg_next.wheel_offset[3] = pwdata[owm_pkg::ANG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            owm_pkg::REG_GAIN: prdata = owm_pkg::APB_DW'(cfg_reg.turn_gain);
            owm_pkg::REG_OFF1: prdata = owm_pkg::APB_DW'(cfg_reg.wheel_offset[0]);
            owm_pkg::REG_OFF2: prdata = owm_pkg::APB_DW'(cfg_reg.wheel_offset[1]);
            owm_pkg::REG_OFF3: prdata = owm_pkg::APB_DW'(cfg_reg.wheel_offset[2]);
            owm_pkg::REG_OFF4: prdata = owm_pkg::APB_DW'(cfg_reg.wheel_offset[3]);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.turn_gain       <= 12'd640;
            cfg_reg.wheel_offset[0] <= 16'd22500;
            cfg_reg.wheel_offset[1] <= 16'd30300;
            cfg_reg.wheel_offset[2] <= 16'd5700;
            cfg_reg.wheel_offset[3] <= 16'd13500;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign pready = 1'b1;
    assign cfg    = cfg_reg;

endmodule

// ===== design/owm_seq.sv =====
// Sequencer and datapath: per-wheel sine by Horner steps on the shared
// multiplier, correction sums, then per-wheel scaling. Uses owm_pkg,
// owm_mul, owm_scale and the channel interfaces.
module owm_seq #(
    parameter int SINE_FRAC_BITS = owm_pkg::SINE_FRAC_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  owm_pkg::cfg_t    cfg,
    owm_cmd_if.sink          cmd_ch,
    owm_res_if.source        res_ch
);

    localparam int F  = SINE_FRAC_BITS;
    localparam int SW = F + 2;
    localparam int PW = F + 30;
    localparam int NW = owm_pkg::WHEELS;

    typedef enum logic [19:0] {
        S_IDLE = 20'h00001,
        S_ANG  = 20'h00002,
        S_RED  = 20'h00004,
        S_X2M  = 20'h00008,
        S_X2   = 20'h00010,
        S_TM   = 20'h00020,
        S_QM   = 20'h00040,
        S_QD   = 20'h00080,
        S_QC   = 20'h00100,
        S_SM   = 20'h00200,
        S_SR   = 20'h00400,
        S_TPM  = 20'h00800,
        S_TP   = 20'h01000,
        S_PM   = 20'h02000,
        S_P    = 20'h04000,
        S_TRM  = 20'h08000,
        S_TR   = 20'h10000,
        S_SCL  = 20'h20000,
        S_SCW  = 20'h40000,
        S_FIN  = 20'h80000
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]                 cmd_reg, cmd_next;
    logic [owm_pkg::ANG_W-1:0]  head_reg, head_next;
    logic signed [owm_pkg::ERR_W-1:0] err_reg, err_next;
    logic [7:0]                 spd_reg, spd_next;
    logic                       en_reg, en_next;
    logic [1:0]                 w_reg, w_next;
    logic [2:0]                 k_reg, k_next;
    logic [17:0]                ang_reg, ang_next;
    logic                       sneg_reg, sneg_next;
    logic [30:0]                x_reg, x_next;
    logic [31:0]                x2_reg, x2_next;
    logic [30:0]                t_reg, t_next;
    logic [31:0]                y_reg, y_next;
    logic [31:0]                q_reg, q_next;
    logic signed [PW:0]         tp_reg, tp_next;
    logic [PW-1:0]              max_reg, max_next;
    logic [PW-1:0]              den_reg, den_next;
    logic [PW-1:0]              num_reg [NW], num_next [NW];
    logic [NW-1:0]              neg_reg, neg_next;
    logic [7:0]                 mag_reg [NW], mag_next [NW];
    logic [NW-1:0]              dirv_reg, dirv_next;
    logic [NW-1:0]              held_reg, held_next;
    logic                       ov_reg, ov_next;
    logic [NW-1:0]              dout_reg, dout_next;
    logic [7:0]                 pout_reg [NW], pout_next [NW];

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic        scl_start, scl_done;
    logic [7:0]  scl_quo;

    // combinational helpers
    logic [14:0]        fold1;
    logic [13:0]        fold_b;
    logic [32:0]        rnd, rsh;
    logic [31:0]        rem;
    logic [31:0]        qfix;
    logic signed [PW:0] pterm, psum, pabs;
    logic signed [17:0] err_x, e_val;
    logic [16:0]        err_abs, e_abs;
    logic [PW-1:0]      tp_mag;
    logic [27:0]        g_mag;
    logic               load_out;

    owm_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    owm_scale #(.NW(PW)) u_scale (
        .clk   (clk),
        .rst_n (rst_n),
        .start (scl_start),
        .num   (num_reg[w_reg]),
        .den   (den_reg),
        .mult  (spd_reg),
        .done  (scl_done),
        .quo   (scl_quo)
    );

    always_comb
    begin
        fold1  = (ang_reg >= 18'(owm_pkg::DEG180)) ? 15'(ang_reg - 18'(owm_pkg::DEG180))
                                                   : 15'(ang_reg);
        fold_b = (fold1 > 15'(owm_pkg::DEG90)) ? 14'(15'(owm_pkg::DEG180) - fold1)
                                               : 14'(fold1);
        rnd    = {1'b0, mul_p[61:30]} + (33'd1 << (29 - F));
        rsh    = rnd >> (30 - F);
        rem    = y_reg - mul_p[31:0];
        qfix   = q_reg + ((rem >= 32'(owm_pkg::term_div(k_reg))) ? 32'd1 : 32'd0);
        pterm  = (PW+1)'(mul_p[PW-1:0]);
        psum   = (neg_reg[w_reg] ? -pterm : pterm) + tp_reg;
        pabs   = psum[PW] ? -psum : psum;
        err_x  = 18'(err_reg);
        err_abs = err_x[17] ? 17'(-err_x) : 17'(err_x);
        e_val  = (err_x >= 18'sd18000) ? err_x - 18'sd36000 : err_x;
        e_abs  = e_val[17] ? 17'(-e_val) : 17'(e_val);
        tp_mag = PW'(mul_p[28:0]) << F;
        g_mag  = mul_p[27:0];
        load_out = !ov_reg || res_ch.ready;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        head_next  = head_reg;
        err_next   = err_reg;
        spd_next   = spd_reg;
        en_next    = en_reg;
        w_next     = w_reg;
        k_next     = k_reg;
        ang_next   = ang_reg;
        sneg_next  = sneg_reg;
        x_next     = x_reg;
        x2_next    = x2_reg;
        t_next     = t_reg;
        y_next     = y_reg;
        q_next     = q_reg;
        tp_next    = tp_reg;
        max_next   = max_reg;
        den_next   = den_reg;
        num_next   = num_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        dirv_next  = dirv_reg;
        held_next  = held_reg;
        ov_next    = ov_reg && !res_ch.ready;
        dout_next  = dout_reg;
        pout_next  = pout_reg;
        mul_a      = '0;
        mul_b      = '0;
        scl_start  = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_ch.valid)
                begin
                    cmd_next  = cmd_ch.cmd;
                    head_next = cmd_ch.heading_angle;
                    err_next  = cmd_ch.turn_error;
                    spd_next  = cmd_ch.speed;
                    en_next   = cmd_ch.motor_enable;
                    w_next    = '0;
                    case (owm_pkg::cmd_t'(cmd_ch.cmd))
                        owm_pkg::CMD_STOP:
                        begin
                            for (int i = 0; i < NW; i++)
                                mag_next[i] = '0;
                            dirv_next  = '0;
                            state_next = S_FIN;
                        end
                        owm_pkg::CMD_TURN: state_next = S_TRM;
                        default:           state_next = S_ANG;
                    endcase
                end
            end
            S_ANG:
            begin
                ang_next   = 18'(cfg.wheel_offset[w_reg]) + 18'(head_reg)
                           + 18'(owm_pkg::DEG180);
                state_next = S_RED;
            end
            S_RED:
            begin
                if (ang_reg >= 18'(owm_pkg::DEG360))
                begin
                    ang_next = ang_reg - 18'(owm_pkg::DEG360);
                end
                else
                begin
                    sneg_next  = ang_reg >= 18'(owm_pkg::DEG180);
                    mul_a      = 32'(fold_b);
                    mul_b      = 32'(owm_pkg::RAD_Q30);
                    state_next = S_X2M;
                end
            end
            S_X2M:
            begin
                x_next     = mul_p[30:0];
                mul_a      = mul_p[31:0];
                mul_b      = mul_p[31:0];
                state_next = S_X2;
            end
            S_X2:
            begin
                x2_next    = mul_p[61:30];
                t_next     = 31'(owm_pkg::Q30_ONE);
                k_next     = '0;
                state_next = S_TM;
            end
            S_TM:
            begin
                mul_a      = x2_reg;
                mul_b      = 32'(t_reg);
                state_next = S_QM;
            end
            S_QM:
            begin
                y_next     = mul_p[61:30];
                mul_a      = mul_p[61:30];
                mul_b      = owm_pkg::term_recip(k_reg);
                state_next = S_QD;
            end
            S_QD:
            begin
                q_next     = mul_p[63:32];
                mul_a      = mul_p[63:32];
                mul_b      = 32'(owm_pkg::term_div(k_reg));
                state_next = S_QC;
            end
            S_QC:
            begin
                t_next = 31'(owm_pkg::Q30_ONE) - qfix[30:0];
                if (k_reg == 3'(owm_pkg::TERM_LAST))
                begin
                    state_next = S_SM;
                end
                else
                begin
                    k_next     = k_reg + 3'd1;
                    state_next = S_TM;
                end
            end
            S_SM:
            begin
                mul_a      = 32'(x_reg);
                mul_b      = 32'(t_reg);
                state_next = S_SR;
            end
            S_SR:
            begin
                num_next[w_reg] = PW'(rsh[SW-1:0]);
                neg_next[w_reg] = sneg_reg;
                if (w_reg == 2'(NW - 1))
                begin
                    w_next = '0;
                    if (owm_pkg::cmd_t'(cmd_reg) == owm_pkg::CMD_CORR)
                    begin
                        state_next = S_TPM;
                    end
                    else
                    begin
                        den_next   = PW'(1) << F;
                        state_next = S_SCL;
                    end
                end
                else
                begin
                    w_next     = w_reg + 2'd1;
                    state_next = S_ANG;
                end
            end
            S_TPM:
            begin
                mul_a      = 32'(cfg.turn_gain);
                mul_b      = 32'(err_abs);
                state_next = S_TP;
            end
            S_TP:
            begin
                tp_next    = err_reg[owm_pkg::ERR_W-1] ? -(PW+1)'(tp_mag) : (PW+1)'(tp_mag);
                max_next   = '0;
                state_next = S_PM;
            end
            S_PM:
            begin
                mul_a      = 32'(num_reg[w_reg][SW-1:0]);
                mul_b      = 32'(owm_pkg::TURN_DIV);
                state_next = S_P;
            end
            S_P:
            begin
                num_next[w_reg] = pabs[PW-1:0];
                neg_next[w_reg] = psum[PW];
                if (pabs[PW-1:0] > max_reg)
                    max_next = pabs[PW-1:0];
                if (w_reg == 2'(NW - 1))
                begin
                    den_next   = (pabs[PW-1:0] > max_reg) ? pabs[PW-1:0] : max_reg;
                    w_next     = '0;
                    state_next = S_SCL;
                end
                else
                begin
                    w_next     = w_reg + 2'd1;
                    state_next = S_PM;
                end
            end
            S_TRM:
            begin
                mul_a      = 32'(cfg.turn_gain);
                mul_b      = 32'(e_abs);
                state_next = S_TR;
            end
            S_TR:
            begin
                for (int i = 0; i < NW; i++)
                begin
                    num_next[i] = (g_mag >= 28'(owm_pkg::TURN_DIV))
                                ? PW'(owm_pkg::TURN_DIV) : PW'(g_mag);
                    neg_next[i] = !e_val[17] && (e_val != '0);
                end
                den_next   = PW'(owm_pkg::TURN_DIV);
                w_next     = '0;
                state_next = S_SCL;
            end
            S_SCL:
            begin
                scl_start  = 1'b1;
                state_next = S_SCW;
            end
            S_SCW:
            begin
                if (scl_done)
                begin
                    // all-zero sums in corrected drive give a zero divisor
                    mag_next[w_reg]  = (den_reg == '0) ? 8'd0 : scl_quo;
                    dirv_next[w_reg] = neg_reg[w_reg] && (den_reg != '0) && (scl_quo != '0);
                    if (w_reg == 2'(NW - 1))
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        w_next     = w_reg + 2'd1;
                        state_next = S_SCL;
                    end
                end
            end
            S_FIN:
            begin
                if (load_out)
                begin
                    ov_next = 1'b1;
                    for (int i = 0; i < NW; i++)
                    begin
                        dout_next[i] = en_reg ? dirv_reg[i] : held_reg[i];
                        pout_next[i] = en_reg ? mag_reg[i] : 8'd0;
                    end
                    if (en_reg)
                        held_next = dirv_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            held_reg  <= '0;
            ov_reg    <= 1'b0;
            w_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            held_reg  <= held_next;
            ov_reg    <= ov_next;
            w_reg     <= w_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        head_reg <= head_next;
        err_reg  <= err_next;
        spd_reg  <= spd_next;
        en_reg   <= en_next;
        ang_reg  <= ang_next;
        sneg_reg <= sneg_next;
        x_reg    <= x_next;
        x2_reg   <= x2_next;
        t_reg    <= t_next;
        y_reg    <= y_next;
        q_reg    <= q_next;
        tp_reg   <= tp_next;
        max_reg  <= max_next;
        den_reg  <= den_next;
        num_reg  <= num_next;
        neg_reg  <= neg_next;
        mag_reg  <= mag_next;
        dirv_reg <= dirv_next;
        dout_reg <= dout_next;
        pout_reg <= pout_next;
    end

    assign cmd_ch.ready     = (state_reg == S_IDLE);
    assign res_ch.valid     = ov_reg;
    assign res_ch.dir_one   = dout_reg[0];
    assign res_ch.pwm_one   = pout_reg[0];
    assign res_ch.dir_two   = dout_reg[1];
    assign res_ch.pwm_two   = pout_reg[1];
    assign res_ch.dir_three = dout_reg[2];
    assign res_ch.pwm_three = pout_reg[2];
    assign res_ch.dir_four  = dout_reg[3];
    assign res_ch.pwm_four  = pout_reg[3];

endmodule

// ===== design/omni_wheel_drive_mixer.sv =====
// Accept to result valid: stop loads the output register directly; turn forms one gain
// product and drive computes four sines on the shared multiplier (corrected drive then
// adds the correction sums), then four serial scale passes; plus any output stall.
// Throughput: one transaction at a time; a new command is taken once the previous
// result sits in the output register.
// Reset: async active-low, loads default gain/offsets and clears held directions.
module omni_wheel_drive_mixer #(
    parameter int SINE_FRAC_BITS = owm_pkg::SINE_FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    owm_cmd_if.sink                       cmd_ch,
    owm_res_if.source                     res_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [owm_pkg::APB_AW-1:0]    paddr,
    input  logic [owm_pkg::APB_DW-1:0]    pwdata,
    output logic [owm_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    owm_pkg::cfg_t cfg;

    owm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    owm_seq #(.SINE_FRAC_BITS(SINE_FRAC_BITS)) u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .cmd_ch (cmd_ch),
        .res_ch (res_ch)
    );

endmodule

// ===== design/owm_chk.sv =====
// Port-level checker for the mixer, attached by bind.
// Depends on owm_pkg.
module owm_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] in_cmd,
    input logic       in_en,
    input logic       out_valid,
    input logic       out_ready,
    input logic       d1,
    input logic       d2,
    input logic       d3,
    input logic       d4,
    input logic [7:0] p1,
    input logic [7:0] p2,
    input logic [7:0] p3,
    input logic [7:0] p4
);

    logic [1:0] cmd_last_reg;
    logic       en_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_last_reg <= '0;
            en_last_reg  <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            cmd_last_reg <= in_cmd;
            en_last_reg  <= in_en;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(p1) && $stable(d1))
        else $error("result dropped or changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transaction taken while busy");

    a_disabled_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (!$past(out_valid) || $past(out_ready)) && !en_last_reg
        |-> p1 == 8'd0 && p2 == 8'd0 && p3 == 8'd0 && p4 == 8'd0)
        else $error("pwm nonzero with motors disabled");

    a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (!$past(out_valid) || $past(out_ready)) && en_last_reg
        && cmd_last_reg == owm_pkg::CMD_STOP
        |-> p1 == 8'd0 && p2 == 8'd0 && p3 == 8'd0 && p4 == 8'd0
            && !d1 && !d2 && !d3 && !d4)
        else $error("stop did not zero the wheels");

endmodule

bind omni_wheel_drive_mixer owm_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cmd_ch.valid),
    .in_ready  (cmd_ch.ready),
    .in_cmd    (cmd_ch.cmd),
    .in_en     (cmd_ch.motor_enable),
    .out_valid (res_ch.valid),
    .out_ready (res_ch.ready),
    .d1        (res_ch.dir_one),
    .d2        (res_ch.dir_two),
    .d3        (res_ch.dir_three),
    .d4        (res_ch.dir_four),
    .p1        (res_ch.pwm_one),
    .p2        (res_ch.pwm_two),
    .p3        (res_ch.pwm_three),
    .p4        (res_ch.pwm_four)
);
